// File: rtl/kvbiv_pkg.sv
// Package: shared types, constants and the CRC-16 step for the bank image validator.
`timescale 1ns / 1ps
package kvbiv_pkg;

  localparam logic [31:0] BANK_MAGIC  = 32'h564B_484A;
  localparam logic [15:0] REC_MAGIC   = 16'hA55A;
  localparam logic [7:0]  FOOT_LO     = 8'hA5;
  localparam logic [7:0]  FOOT_HI     = 8'h5A;
  localparam logic [7:0]  BANK_VER    = 8'd2;
  localparam logic [15:0] BANK_HDR_SZ = 16'd24;
  localparam logic [15:0] HDR_BYTES   = 16'd24;
  localparam logic [15:0] REC_HDR_LEN = 16'd16;
  localparam logic [15:0] REC_OVH     = 16'd18;
  localparam logic [7:0]  TYPE_FIXED  = 8'd1;
  localparam logic [7:0]  TYPE_VAR    = 8'd2;
  localparam logic [7:0]  TYPE_EMPTY  = 8'd3;
  localparam logic [15:0] FIXED_LEN   = 16'd4;
  localparam logic [15:0] POLY        = 16'h1021;

  // configuration register indexes
  localparam logic CFG_BANK_LEN = 1'b0;
  localparam logic CFG_CRC_INIT = 1'b1;

  typedef enum logic [3:0] {
    ERR_NONE    = 4'd0,
    ERR_HDR_FLD = 4'd1,
    ERR_HDR_CRC = 4'd2,
    ERR_BODY    = 4'd3,
    ERR_OVERRUN = 4'd4,
    ERR_REC_FLD = 4'd5,
    ERR_REC_CRC = 4'd6,
    ERR_PAY_CRC = 4'd7,
    ERR_FOOTER  = 4'd8,
    ERR_COUNT   = 4'd9,
    ERR_TRUNC   = 4'd10
  } err_e;

  // Queue entry: one byte tagged with its image position
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        in_hdr;
    logic [15:0] pos;
  } q_entry_t;

  typedef struct packed {
    logic        valid_res;
    logic [3:0]  error_code;
    logic [31:0] generation;
    logic [15:0] used_end;
    logic [15:0] rec_total;
  } verdict_t;

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      x = x[15] ? ((x << 1) ^ POLY) : (x << 1);
    end
    return x;
  endfunction

endpackage

// File: rtl/kvbiv_if.sv
// Interfaces: byte input channel and verdict output channel.
`timescale 1ns / 1ps
interface kvbiv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;
  logic       last;
  modport source (output valid, output image_byte, output last, input ready);
  modport sink (input valid, input image_byte, input last, output ready);
endinterface

interface kvbiv_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [3:0]  error_code;
  logic [31:0] generation;
  logic [15:0] used_end;
  logic [15:0] rec_total;
  modport source (output valid, output valid_res, output error_code, output generation,
                  output used_end, output rec_total, input ready);
  modport sink (input valid, input valid_res, input error_code, input generation,
                input used_end, input rec_total, output ready);
endinterface

// File: rtl/kvbiv_front.sv
// Front end: accepts bytes, tags position and region, queues them for the checker.
`timescale 1ns / 1ps
module kvbiv_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output kvbiv_pkg::q_entry_t  q_head_o
);
  import kvbiv_pkg::*;

  localparam int unsigned DEPTH = 4;

  q_entry_t    mem_q [DEPTH];
  logic [1:0]  wptr_q, rptr_q;
  logic [2:0]  fill_q;
  logic [15:0] pos_q;
  logic        push;

  assign in_ready_o = (fill_q != 3'(DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (fill_q != 3'd0);
  assign q_head_o   = mem_q[rptr_q];

  // position counter, saturating, cleared after the last byte; queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        if (in_last_i) begin
          pos_q <= '0;
        end else if (pos_q != 16'hFFFF) begin
          pos_q <= pos_q + 16'd1;
        end
        wptr_q <= wptr_q + 2'd1;
      end
      if (q_pop_i) rptr_q <= rptr_q + 2'd1;
      fill_q <= fill_q + {2'b00, push} - {2'b00, q_pop_i};
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= '{data: in_byte_i, last: in_last_i,
                         in_hdr: (pos_q < HDR_BYTES), pos: pos_q};
    end
  end

endmodule

// File: rtl/kvbiv_back.sv
// Back end: header decode, record walk, CRC runs and verdict register.
`timescale 1ns / 1ps
module kvbiv_back #(
  parameter int unsigned PUBLISH_BYTES  = 32,
  parameter int unsigned MAX_BANK_BYTES = 2048
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [11:0]          bank_len_i,
  input  logic [15:0]          crc_init_i,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  kvbiv_pkg::q_entry_t  q_head_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output kvbiv_pkg::verdict_t  res_o
);
  import kvbiv_pkg::*;

  localparam logic [15:0] PUB = 16'(PUBLISH_BYTES);
  localparam logic [16:0] MAXB = 17'(MAX_BANK_BYTES);

  logic [7:0]  hdr_q [24];
  logic [7:0]  rh_q [16];
  logic [15:0] hcrc_q, hcrc_d, bcrc_q, bcrc_d, rcrc_q, rcrc_d, pcrc_q, pcrc_d;
  logic [15:0] rstart_q, rstart_d, ridx_q, ridx_d, cnt_q, cnt_d;
  err_e        ferr_q, ferr_d;
  logic        hok_q, hok_d;
  logic        rvalid_q;
  verdict_t    res_q, verdict;

  logic        take;
  logic [7:0]  b;
  logic [15:0] p, used, len, hin, rin, pn, hcrc_rx;
  logic [17:0] start18, end18, idx18, len18;
  logic        body, tok;
  err_e        code;
  logic [16:0] count;

  // only a last byte waits for the result register
  assign take    = q_valid_i && (!rvalid_q || res_ready_i || !q_head_i.last);
  assign q_pop_o = take;
  assign b       = q_head_i.data;
  assign p       = q_head_i.pos;
  assign used    = {hdr_q[13], hdr_q[12]};
  assign len     = {rh_q[7], rh_q[6]};
  assign start18 = {2'b00, rstart_q};
  assign len18   = {2'b00, len};
  assign idx18   = {2'b00, ridx_q};
  assign end18   = start18 + {2'b00, REC_OVH} + len18;
  assign hin     = (p == 16'd0) ? crc_init_i : hcrc_q;
  assign rin     = (ridx_q == 16'd0) ? crc_init_i : rcrc_q;
  assign pn      = crc16_step(pcrc_q, b);
  assign hcrc_rx = {b, hdr_q[22]};
  assign body    = !q_head_i.in_hdr && hok_q && (p >= PUB) && (p < used);
  assign tok     = (rh_q[4] == TYPE_FIXED && len == FIXED_LEN) || rh_q[4] == TYPE_VAR ||
                   (rh_q[4] == TYPE_EMPTY && len == 16'd0);

  // per-byte state update
  always_comb begin
    hcrc_d   = hcrc_q;
    bcrc_d   = bcrc_q;
    rcrc_d   = rcrc_q;
    pcrc_d   = pcrc_q;
    rstart_d = rstart_q;
    ridx_d   = ridx_q;
    cnt_d    = cnt_q;
    ferr_d   = ferr_q;
    hok_d    = hok_q;
    if (q_head_i.in_hdr) begin
      if (p < 16'd22) hcrc_d = crc16_step(hin, b);
      if (p == 16'd23) begin
        if ({hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]} != BANK_MAGIC ||
            hdr_q[4] != BANK_VER || {hdr_q[7], hdr_q[6]} != BANK_HDR_SZ ||
            {5'd0, bank_len_i} > MAXB || {hdr_q[15], hdr_q[14]} != {4'd0, bank_len_i} ||
            used < PUB || used > {4'd0, bank_len_i}) begin
          ferr_d = ERR_HDR_FLD;
        end else if (hcrc_q != hcrc_rx) begin
          ferr_d = ERR_HDR_CRC;
        end else begin
          hok_d  = 1'b1;
          bcrc_d = crc_init_i;
        end
      end
    end else if (body) begin
      bcrc_d = crc16_step(bcrc_q, b);
      if (ferr_q == ERR_NONE) begin
        ridx_d = ridx_q + 16'd1;
        if (ridx_q == 16'd0 && (start18 + {2'b00, REC_OVH}) > {2'b00, used}) begin
          ferr_d = ERR_OVERRUN;
        end else if (ridx_q < REC_HDR_LEN) begin
          if (ridx_q < 16'd14) rcrc_d = crc16_step(rin, b);
          if (ridx_q == 16'd15) begin
            pcrc_d = crc_init_i;
            if ({rh_q[1], rh_q[0]} != REC_MAGIC || rh_q[5] != 8'd0 || !tok) begin
              ferr_d = ERR_REC_FLD;
            end else if (rcrc_q != {b, rh_q[14]}) begin
              ferr_d = ERR_REC_CRC;
            end else if (end18 > {2'b00, used}) begin
              ferr_d = ERR_OVERRUN;
            end else if (len == 16'd0 && crc_init_i != {rh_q[13], rh_q[12]}) begin
              ferr_d = ERR_PAY_CRC;
            end
          end
        end else if (idx18 < 18'd16 + len18) begin
          pcrc_d = pn;
          if (idx18 == 18'd15 + len18 && pn != {rh_q[13], rh_q[12]}) ferr_d = ERR_PAY_CRC;
        end else if (idx18 == 18'd16 + len18) begin
          if (b != FOOT_LO) ferr_d = ERR_FOOTER;
        end else begin
          if (b != FOOT_HI) begin
            ferr_d = ERR_FOOTER;
          end else begin
            cnt_d    = cnt_q + 16'd1;
            rstart_d = end18[15:0];
            ridx_d   = '0;
          end
        end
      end
    end
  end

  // verdict for a last byte
  assign count = {1'b0, p} + 17'd1;
  always_comb begin
    priority if (count < 17'd24) code = ERR_TRUNC;
    else if (ferr_d == ERR_HDR_FLD || ferr_d == ERR_HDR_CRC) code = ferr_d;
    else if (count < {1'b0, used}) code = ERR_TRUNC;
    else if (bcrc_d != {hdr_q[19], hdr_q[18]}) code = ERR_BODY;
    else if (ferr_d != ERR_NONE) code = ferr_d;
    else if (cnt_d != {hdr_q[17], hdr_q[16]}) code = ERR_COUNT;
    else code = ERR_NONE;
    verdict.valid_res  = (code == ERR_NONE);
    verdict.error_code = code;
    verdict.generation = verdict.valid_res ?
                         {hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]} : 32'd0;
    verdict.used_end   = verdict.valid_res ? used : 16'd0;
    verdict.rec_total  = verdict.valid_res ? {hdr_q[17], hdr_q[16]} : 16'd0;
  end

  // control state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hok_q    <= 1'b0;
      ferr_q   <= ERR_NONE;
      ridx_q   <= '0;
      rstart_q <= PUB;
      cnt_q    <= '0;
      hcrc_q   <= 16'hFFFF;
      bcrc_q   <= 16'hFFFF;
      rcrc_q   <= 16'hFFFF;
      pcrc_q   <= 16'hFFFF;
      rvalid_q <= 1'b0;
    end else begin
      if (take && q_head_i.last) rvalid_q <= 1'b1;
      else if (res_ready_i) rvalid_q <= 1'b0;
      if (take) begin
        hcrc_q <= hcrc_d;
        bcrc_q <= bcrc_d;
        rcrc_q <= rcrc_d;
        pcrc_q <= pcrc_d;
        if (q_head_i.last) begin
          hok_q    <= 1'b0;
          ferr_q   <= ERR_NONE;
          ridx_q   <= '0;
          rstart_q <= PUB;
          cnt_q    <= '0;
        end else begin
          hok_q    <= hok_d;
          ferr_q   <= ferr_d;
          ridx_q   <= ridx_d;
          rstart_q <= rstart_d;
          cnt_q    <= cnt_d;
        end
      end
    end
  end

  // byte stores and result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (q_head_i.in_hdr) hdr_q[p[4:0]] <= b;
      if (body && ferr_q == ERR_NONE && ridx_q < REC_HDR_LEN) rh_q[ridx_q[3:0]] <= b;
      if (q_head_i.last) res_q <= verdict;
    end
  end

  assign res_valid_o = rvalid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/kv_bank_image_validator_core.sv
// Bank image validator: header and log record checks over a byte stream.
//
// Usage: bytes of a bank image enter on in_if, one item per byte in address
// order, with last set on the final byte. For each last byte one verdict item
// leaves on out_if: pass flag, error code, generation, used offset and count.
// Configuration (bank length at index 0, crc_init at index 1) is to be written
// through cfg_we_i / cfg_idx_i / cfg_data_i only while no image is in flight;
// the block does not enforce this. Throughput: one byte per cycle while the
// queue has room; each byte needs at most two CRC-16 steps and a few field
// compares in the checker stage. The verdict is registered: the last byte goes
// through the queue, then waits there for a free result register.
// When the receiver stalls, the verdict is held; bytes of the next image go on
// being checked until its last byte reaches the checker, then the four-entry
// queue fills and in_if.ready drops.
// Reset clears the stream state, empties the queue and restores the bank
// length to 2048 and crc_init to 0xFFFF. No clearing pass is needed.
`timescale 1ns / 1ps
module kv_bank_image_validator_core #(
  parameter int unsigned PUBLISH_BYTES  = 32,
  parameter int unsigned MAX_BANK_BYTES = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  kvbiv_in_if.sink           in_if,
  kvbiv_out_if.source        out_if,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  import kvbiv_pkg::*;

  logic [11:0] bank_len_q;
  logic [15:0] crc_init_q;
  logic        q_valid, q_pop;
  q_entry_t    q_head;
  verdict_t    res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_len_q <= 12'd2048;
      crc_init_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BANK_LEN: bank_len_q <= cfg_data_i[11:0];
        CFG_CRC_INIT: crc_init_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  kvbiv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .in_byte_i  (in_if.image_byte),
    .in_last_i  (in_if.last),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_head_o   (q_head)
  );

  kvbiv_back #(
    .PUBLISH_BYTES  (PUBLISH_BYTES),
    .MAX_BANK_BYTES (MAX_BANK_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bank_len_i  (bank_len_q),
    .crc_init_i  (crc_init_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_head_i    (q_head),
    .res_valid_o (out_if.valid),
    .res_ready_i (out_if.ready),
    .res_o       (res)
  );

  assign out_if.valid_res  = res.valid_res;
  assign out_if.error_code = res.error_code;
  assign out_if.generation = res.generation;
  assign out_if.used_end   = res.used_end;
  assign out_if.rec_total  = res.rec_total;

endmodule
